// ===== rtl/srl_pkg.sv =====
// Package with shared constants, types and the key compare function of the sorted record list.
`timescale 1ns / 1ps
package srl_pkg;

  // List size and derived widths.
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CALC_W   = (CNT_W > 5) ? CNT_W : 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_SORTED = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPARE,
    S_APPLY
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LOWER,
    CELL_FROM_UPPER
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     cmp_en;
  } cell_ctrl_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flags_t;

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [63:0] given_high;
    logic [63:0] given_mid;
    logic [63:0] given_low;
    logic [7:0]  init_char;
    logic [6:0]  age;
  } record_t;

  // String order of stored key a against given key b. Byte 0 sits in the top bits.
  // Walking from the last byte to the first leaves the first stopping byte in charge.
  function automatic cell_flags_t key_compare(logic [127:0] a, logic [127:0] b);
    cell_flags_t r;
    logic [7:0]  ab;
    logic [7:0]  bb;
    r.lt = 1'b0;
    r.eq = 1'b1;
    for (int n = 15; n >= 0; n--) begin
      ab = a[(15 - n) * 8 +: 8];
      bb = b[(15 - n) * 8 +: 8];
      if (ab != bb) begin
        r.lt = (ab < bb);
        r.eq = 1'b0;
      end else if (ab == 8'd0) begin
        r.lt = 1'b0;
        r.eq = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/srl_cell.sv =====
// One cell of the record chain: holds one entry, compares its key and moves data to neighbors.
`timescale 1ns / 1ps
module srl_cell (
  input  logic                clk,
  input  srl_pkg::cell_ctrl_t ctrl,
  input  srl_pkg::record_t    cmd_rec,
  input  srl_pkg::record_t    lower_rec,
  input  srl_pkg::record_t    upper_rec,
  output srl_pkg::record_t    rec,
  output srl_pkg::cell_flags_t flags
);
  import srl_pkg::*;

  // Entry storage: load the new record or take a neighbor's entry during a shift.
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      CELL_HOLD:       rec <= rec;
      CELL_LOAD:       rec <= cmd_rec;
      CELL_FROM_LOWER: rec <= lower_rec;
      CELL_FROM_UPPER: rec <= upper_rec;
      default:         rec <= rec;
    endcase
  end

  // Key compare against the command key, kept for the apply cycle.
  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      flags <= key_compare({rec.key_high, rec.key_low}, {cmd_rec.key_high, cmd_rec.key_low});
    end
  end

endmodule

// ===== rtl/sorted_record_list_core.sv =====
// Top level of the sorted record list: command register, sequencer and the chain of cells.
`timescale 1ns / 1ps
// A command is taken when start is high and busy is low. The cycle after the transfer every
// cell compares its key with the command key at once; the next cycle finds the position
// (from the compare flags for search and sorted insert) and, for an insert or delete,
// shifts the entries from that position on by one cell. The result appears on status,
// where_found and entries with done high for the single following cycle, in which busy
// is already low again and a new command may be transferred. No new command is taken
// during the compare and apply steps. The receiver cannot stall: results must be taken
// in the cycle done is high. Entries at or beyond the count are never read.
module sorted_record_list_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [4:0]  position,
  input  logic [63:0] key_high,
  input  logic [63:0] key_low,
  input  logic [63:0] given_high,
  input  logic [63:0] given_mid,
  input  logic [63:0] given_low,
  input  logic [7:0]  initial_in,
  input  logic [6:0]  age_in,
  output logic        done,
  output logic [1:0]  status,
  output logic [3:0]  where_found,
  output logic [4:0]  entries
);
  import srl_pkg::*;

  state_t              state;
  state_t              state_next;
  cmd_t                cmd_q;
  logic [4:0]          pos_q;
  record_t             cmd_rec;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic                accept;
  logic                cmp_en;
  logic                apply_en;

  record_t             cell_rec   [CAPACITY];
  cell_flags_t         cell_flags [CAPACITY];
  cell_ctrl_t          cell_ctrl  [CAPACITY];

  logic                found;
  logic [CALC_W-1:0]   found_idx;
  logic [CALC_W-1:0]   ge_idx;
  logic [CALC_W-1:0]   pos_ext;
  logic [CALC_W-1:0]   count_ext;
  logic                do_insert;
  logic                do_delete;
  logic [CALC_W-1:0]   op_pos;
  status_t             res_status;
  logic [CALC_W-1:0]   res_where;

  assign accept    = start && !busy;
  assign pos_ext   = CALC_W'(pos_q);
  assign count_ext = CALC_W'(count);

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (start) state_next = S_COMPARE;
      S_COMPARE: state_next = S_APPLY;
      S_APPLY:   state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy     = 1'b1;
    cmp_en   = 1'b0;
    apply_en = 1'b0;
    unique case (state)
      S_IDLE:    busy = 1'b0;
      S_COMPARE: cmp_en = 1'b1;
      S_APPLY:   apply_en = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  // Command register, loaded on each input transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q              <= cmd_t'(command);
      pos_q              <= position;
      cmd_rec.key_high   <= key_high;
      cmd_rec.key_low    <= key_low;
      cmd_rec.given_high <= given_high;
      cmd_rec.given_mid  <= given_mid;
      cmd_rec.given_low  <= given_low;
      cmd_rec.init_char  <= initial_in;
      cmd_rec.age        <= age_in;
    end
  end

  // First valid cell with an equal key, and first valid cell whose key is not less.
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    ge_idx    = count_ext;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (CALC_W'(i) < count_ext) begin
        if (cell_flags[i].eq) begin
          found     = 1'b1;
          found_idx = CALC_W'(i);
        end
        if (!cell_flags[i].lt) begin
          ge_idx = CALC_W'(i);
        end
      end
    end
  end

  // Command decode: status, reported position and the move the chain makes.
  always_comb begin
    res_status = ST_OK;
    res_where  = '0;
    do_insert  = 1'b0;
    do_delete  = 1'b0;
    op_pos     = pos_ext;
    count_next = count;
    unique case (cmd_q)
      CMD_INSERT: begin
        if (count == CNT_W'(CAPACITY)) begin
          res_status = ST_FULL;
        end else if (pos_ext > count_ext) begin
          res_status = ST_BAD_POS;
          res_where  = pos_ext;
        end else begin
          res_where  = pos_ext;
          do_insert  = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_DELETE: begin
        res_where = pos_ext;
        if (pos_ext >= count_ext) begin
          res_status = ST_BAD_POS;
        end else begin
          do_delete  = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      CMD_SEARCH: begin
        if (found) begin
          res_where = found_idx;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      CMD_SORTED: begin
        op_pos = ge_idx;
        if (count == CNT_W'(CAPACITY)) begin
          res_status = ST_FULL;
        end else begin
          res_where  = ge_idx;
          do_insert  = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      default: res_status = ST_OK;
    endcase
  end

  // Per-cell control: insert opens a gap at the position, delete closes it.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ctrl[i].cmp_en = cmp_en;
      cell_ctrl[i].op     = CELL_HOLD;
      if (apply_en && do_insert) begin
        if (CALC_W'(i) == op_pos) begin
          cell_ctrl[i].op = CELL_LOAD;
        end else if (CALC_W'(i) > op_pos && CALC_W'(i) <= count_ext) begin
          cell_ctrl[i].op = CELL_FROM_LOWER;
        end
      end else if (apply_en && do_delete) begin
        if (CALC_W'(i) >= op_pos && CALC_W'(i) + CALC_W'(1) < count_ext) begin
          cell_ctrl[i].op = CELL_FROM_UPPER;
        end
      end
    end
  end

  // The chain of cells; the end cells see the command record as their missing neighbor.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    record_t lower_rec;
    record_t upper_rec;
    if (g == 0) begin : g_first
      assign lower_rec = cmd_rec;
    end else begin : g_inner_lo
      assign lower_rec = cell_rec[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign upper_rec = cmd_rec;
    end else begin : g_inner_hi
      assign upper_rec = cell_rec[g+1];
    end
    srl_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[g]),
      .cmd_rec   (cmd_rec),
      .lower_rec (lower_rec),
      .upper_rec (upper_rec),
      .rec       (cell_rec[g]),
      .flags     (cell_flags[g])
    );
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (apply_en) begin
      count <= count_next;
    end
  end

  // Result register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= apply_en;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_en) begin
      status      <= res_status;
      where_found <= res_where[3:0];
      entries     <= 5'(count_next);
    end
  end

  // Checks on the sequencer and the count.
  a_apply_gives_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) |=> done)
    else $error("apply cycle not followed by a result strobe");

  a_transfer_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command transfer did not make the block busy");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_count_steps_by_one: assert property (@(posedge clk) disable iff (rst)
    apply_en |=> (count == $past(count) || count == $past(count) + CNT_W'(1) ||
                  count + CNT_W'(1) == $past(count)))
    else $error("entry count changed by more than one");

endmodule
